FILE: rtl/core/timer_task_descriptor_table_assert.svh
// Assertion macros for the timer task descriptor table.
`ifndef TIMER_TASK_DESCRIPTOR_TABLE_ASSERT_SVH
`define TIMER_TASK_DESCRIPTOR_TABLE_ASSERT_SVH
// Check that an implication holds on every clock edge out of reset.
`define TTDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer task table check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define TTDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer task table sequencing check failed");
`endif

FILE: rtl/core/ttdt_pkg.sv
// Package with shared types, codes and constants of the timer task table.
package ttdt_pkg;
  localparam int unsigned TableEntriesDef = 64;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpPrime  = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StReinsert = 2'd1,
    StFull     = 2'd2,
    StMissing  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] task_addr;
    logic [15:0] trap_word;
    logic signed [31:0] delay_code;
    logic        wakeup_marked;
    logic [63:0] now_us;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        write_count;
    logic signed [31:0] count_value;
    logic        set_wakeup_mark;
    logic [5:0]  slot;
  } rsp_t;

  localparam logic [31:0] CountMax = 32'h7fff_ffff;
  localparam int unsigned TrapExtBit = 10;
endpackage

FILE: rtl/core/ttdt_if.sv
// Valid/ready channel interface carrying one request or response item.
interface ttdt_req_if;
  import ttdt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttdt_rsp_if;
  import ttdt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/ttdt_remain.sv
// Remaining-time encoder: microseconds to millisecond count by reciprocal multiplication.
module ttdt_remain (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] t_i,
  output logic        done_o,
  output logic [31:0] code_o
);
  import ttdt_pkg::*;

  // ceil(2^45 / 125), split at bit 32; exact for dividends below 2^38
  localparam logic [31:0] RecipLo = 32'h8937_4bc7;
  localparam logic [6:0]  RecipHi = 7'h41;

  logic        stage1_q, stage2_q;
  logic        sat1_q, sat2_q;
  logic [37:0] y_q;
  logic [63:0] p_ll_q;
  logic [39:0] p_cross_q;
  logic [12:0] p_hh_q;
  logic [76:0] prod;
  logic [31:0] quo;

  // Advance the two pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
    end else begin
      stage1_q <= start_i;
      stage2_q <= stage1_q;
    end
  end

  // Divide by 8 up front, flag remainders that saturate, then form partial products.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      y_q    <= t_i[40:3];
      sat1_q <= (t_i[63:41] != '0);
    end
    if (stage1_q) begin
      p_ll_q    <= 64'(y_q[31:0]) * 64'(RecipLo);
      p_cross_q <= 40'(y_q[31:0]) * 40'(RecipHi) + 40'(y_q[37:32]) * 40'(RecipLo);
      p_hh_q    <= 13'(y_q[37:32]) * 13'(RecipHi);
      sat2_q    <= sat1_q;
    end
  end

  // Sum the partial products and saturate the millisecond quotient.
  assign prod   = 77'(p_ll_q) + (77'(p_cross_q) << 32) + (77'(p_hh_q) << 64);
  assign quo    = prod[76:45];
  assign done_o = stage2_q;
  assign code_o = (sat2_q || quo[31]) ? CountMax : quo;
endmodule

FILE: rtl/core/timer_task_descriptor_table.sv
// Top level of the timer task descriptor table.
// Timer task descriptor table: keeps up to TABLE_ENTRIES timer tasks keyed by
// the task record address. Each item is one operation (insert, remove, prime,
// clear) and yields exactly one result item. The key, extended bit and wakeup
// time live in a synchronous memory; valid and active bits are flip-flops.
// Items are handled one at a time: a lookup walks the memory one entry per
// cycle for insert, remove and prime; a remove whose remainder exceeds
// 2147483647 us also runs the reciprocal multiply that divides by 1000.
// Clear skips the scan. No clearing pass follows reset.
module timer_task_descriptor_table #(
  parameter int unsigned TABLE_ENTRIES = ttdt_pkg::TableEntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  ttdt_req_if.sink   req,
  ttdt_rsp_if.source rsp
);
  import ttdt_pkg::*;
  `include "timer_task_descriptor_table_assert.svh"

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(TABLE_ENTRIES - 1);

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SScan   = 6'b000010,
    SAct    = 6'b000100,
    SRead   = 6'b001000,
    SDiv    = 6'b010000,
    SOut    = 6'b100000
  } state_e;

  typedef struct packed {
    logic        ext;
    logic [31:0] key;
    logic [63:0] wakeup;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa, mem_ra;
  entry_t            mem_wd;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d, active_q, active_d;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] hit_q, hit_d, free_q, free_d, pidx_q;
  logic hit_ok_q, hit_ok_d, free_ok_q, free_ok_d, pend_q;

  logic [63:0] delay_us, t_rem, base;
  logic [31:0] code_u;
  logic        div_start, div_done;
  logic [31:0] div_code;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= mem_ra;
    pend_q <= (state_q == SScan);
  end

  // Delay code to microseconds.
  always_comb begin
    code_u = req_q.delay_code;
    if (!code_u[31] && code_u != '0) begin
      delay_us = 64'(code_u) * 64'd1000;
    end else begin
      delay_us = 64'(32'(0 - code_u));
    end
  end

  assign t_rem = rd_q.wakeup - req_q.now_us;
  assign base  = (rd_q.ext && req_q.wakeup_marked) ? rd_q.wakeup : req_q.now_us;

  ttdt_remain u_remain (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .t_i     (t_rem),
    .done_o  (div_done),
    .code_o  (div_code)
  );

  assign req.ready = (state_q == SIdle);
  assign rsp.valid = (state_q == SOut);
  assign rsp.data  = rsp_q;

  // Sequencer: scan, pick the entry, read it back, modify and write, report.
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    active_d  = active_q;
    rsp_d     = rsp_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    free_d    = free_q;
    hit_ok_d  = hit_ok_q;
    free_ok_d = free_ok_q;
    mem_we    = 1'b0;
    mem_wa    = hit_q;
    mem_wd    = rd_q;
    mem_ra    = cnt_q[IdxW-1:0];
    div_start = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (req.valid) begin
          rsp_d     = '0;
          cnt_d     = '0;
          hit_ok_d  = 1'b0;
          free_ok_d = 1'b0;
          if (op_e'(req.data.operation) == OpClear) begin
            valid_d  = '0;
            active_d = '0;
            state_d  = SOut;
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        if (cnt_q == LastCnt) begin
          state_d = SAct;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: ;
    endcase
    // Evaluate the entry whose read returned this cycle.
    if (pend_q) begin
      if (valid_q[pidx_q] && rd_q.key == req_q.task_addr && !hit_ok_d) begin
        hit_ok_d = 1'b1;
        hit_d    = pidx_q;
      end
      if (!valid_q[pidx_q] && !free_ok_d) begin
        free_ok_d = 1'b1;
        free_d    = pidx_q;
      end
    end
    unique case (state_q)
      SAct: begin
        state_d = SOut;
        unique case (op_e'(req_q.operation))
          OpInsert: begin
            if (hit_ok_d) begin
              rsp_d.status = StReinsert;
              state_d = SRead;
            end else if (free_ok_d) begin
              hit_d   = free_d;
              state_d = SRead;
            end else begin
              rsp_d.status = StFull;
            end
          end
          OpRemove, OpPrime: begin
            if (!hit_ok_d) begin
              rsp_d.status = StMissing;
            end else begin
              state_d = SRead;
            end
          end
          default: ;
        endcase
        mem_ra = hit_d;
      end
      SRead: begin
        rsp_d.slot = 6'(hit_q);
        state_d    = SOut;
        unique case (op_e'(req_q.operation))
          OpInsert: begin
            mem_we          = 1'b1;
            mem_wd.ext      = req_q.trap_word[TrapExtBit];
            mem_wd.key      = req_q.task_addr;
            valid_d[hit_q]  = 1'b1;
            active_d[hit_q] = 1'b0;
          end
          OpPrime: begin
            mem_we          = 1'b1;
            mem_wd.wakeup   = base + delay_us;
            active_d[hit_q] = 1'b1;
            rsp_d.set_wakeup_mark = rd_q.ext;
          end
          OpRemove: begin
            rsp_d.write_count = 1'b1;
            valid_d[hit_q]  = 1'b0;
            active_d[hit_q] = 1'b0;
            if (active_q[hit_q] && rd_q.wakeup >= req_q.now_us) begin
              if (t_rem > 64'(CountMax)) begin
                div_start = 1'b1;
                state_d   = SDiv;
              end else begin
                rsp_d.count_value = 32'(0 - t_rem[31:0]);
              end
            end
          end
          default: ;
        endcase
      end
      SDiv: begin
        if (div_done) begin
          rsp_d.count_value = div_code;
          state_d = SOut;
        end
      end
      SOut: begin
        if (rsp.ready) state_d = SIdle;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      valid_q   <= '0;
      active_q  <= '0;
      cnt_q     <= '0;
      hit_ok_q  <= 1'b0;
      free_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      hit_ok_q  <= hit_ok_d;
      free_ok_q <= free_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q  <= rsp_d;
    hit_q  <= hit_d;
    free_q <= free_d;
    if (req.valid && req.ready) req_q <= req.data;
  end

  // Checks on the sequencer.
  `TTDT_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `TTDT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, req.valid && req.ready, !req.ready)
  `TTDT_ASSERT_IMP(a_wc_status, clk_i, rst_ni, rsp.valid && rsp.data.write_count,
                   rsp.data.status == StOk)
endmodule

FILE: dv/tb_timer_task_descriptor_table.sv
// Testbench for the timer task descriptor table: random and directed items vs. a predictor.
`timescale 1ns / 1ps
module tb_timer_task_descriptor_table;
  import ttdt_pkg::*;

  localparam int NumSlots = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ttdt_req_if req_ch ();
  ttdt_rsp_if rsp_ch ();

  timer_task_descriptor_table DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // Shadow table
  bit          tbl_valid[NumSlots];
  bit          tbl_active[NumSlots];
  bit          tbl_ext[NumSlots];
  bit          tbl_woken[NumSlots];
  logic [31:0] tbl_key[NumSlots];
  logic [63:0] tbl_wake[NumSlots];

  req_t pending_ops[$];
  rsp_t expected_rsps[$];
  int   error_count = 0;
  bit   stim_done = 1'b0;
  bit   quiet_mode = 1'b0;
  int   pick_calls = 0;

  function automatic int find_task(logic [31:0] key);
    for (int k = 0; k < NumSlots; k++) begin
      if (tbl_valid[k] && tbl_key[k] == key) return k;
    end
    return -1;
  endfunction

  function automatic logic [63:0] delay_in_us(logic [31:0] code);
    if (!code[31] && code != 0) return 64'(code) * 64'd1000;
    return 64'(32'(0 - code));
  endfunction

  function automatic logic [31:0] remaining_count(logic [63:0] wake, logic [63:0] now);
    logic [63:0] t;
    logic [63:0] ms;
    if (wake < now) return 32'd0;
    t = wake - now;
    if (t > 64'h7fff_ffff) begin
      ms = t / 64'd1000;
      if (ms > 64'h7fff_ffff) ms = 64'h7fff_ffff;
      return ms[31:0];
    end
    return 32'(0 - t[31:0]);
  endfunction

  // Advance the shadow table by one operation and return the expected result
  function automatic rsp_t apply_op(req_t r);
    rsp_t o;
    int k;
    o = '0;
    o.status = StOk;
    case (op_e'(r.operation))
      OpInsert: begin
        k = find_task(r.task_addr);
        if (k >= 0) begin
          o.status = StReinsert;
        end else begin
          for (int j = 0; j < NumSlots; j++) begin
            if (!tbl_valid[j]) begin
              k = j;
              break;
            end
          end
          if (k >= 0) begin
            tbl_valid[k] = 1'b1;
            tbl_key[k] = r.task_addr;
          end
        end
        if (k >= 0) begin
          tbl_ext[k] = r.trap_word[TrapExtBit];
          tbl_active[k] = 1'b0;
          o.slot = 6'(k);
        end else begin
          o.status = StFull;
        end
      end
      OpRemove: begin
        k = find_task(r.task_addr);
        if (k < 0) begin
          o.status = StMissing;
        end else begin
          o.write_count = 1'b1;
          if (tbl_active[k]) o.count_value = remaining_count(tbl_wake[k], r.now_us);
          tbl_active[k] = 1'b0;
          tbl_valid[k] = 1'b0;
          o.slot = 6'(k);
        end
      end
      OpPrime: begin
        k = find_task(r.task_addr);
        if (k < 0) begin
          o.status = StMissing;
        end else begin
          if (tbl_ext[k] && r.wakeup_marked)
            tbl_wake[k] = tbl_wake[k] + delay_in_us(r.delay_code);
          else
            tbl_wake[k] = r.now_us + delay_in_us(r.delay_code);
          o.set_wakeup_mark = tbl_ext[k];
          tbl_woken[k] = 1'b1;
          tbl_active[k] = 1'b1;
          o.slot = 6'(k);
        end
      end
      default: begin
        for (int j = 0; j < NumSlots; j++) begin
          tbl_valid[j] = 1'b0;
          tbl_active[j] = 1'b0;
        end
      end
    endcase
    return o;
  endfunction

  // Stimulus-side check that a key is absent or already primed, to keep wakeup reads defined
  function automatic bit marked_safe(logic [31:0] key);
    int k;
    k = find_task(key);
    return (k < 0) || tbl_woken[k];
  endfunction

  logic [31:0] key_pool[8];

  function automatic logic [63:0] rand_now();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return 64'(32'h4000_0000) + 64'($urandom_range(0, 100000));
    endcase
  endfunction

  function automatic logic [31:0] rand_delay();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($urandom_range(1, 5000));
      4: return 32'(0 - $urandom_range(1, 100000));
      default: return $urandom;
    endcase
  endfunction

  // Build one operation; the shadow table is advanced in stimulus order
  task automatic queue_op(op_e op, logic [31:0] key, logic [15:0] trap,
                          logic [31:0] delay, bit marked, logic [63:0] now);
    req_t r;
    r.operation = op;
    r.task_addr = key;
    r.trap_word = trap;
    r.delay_code = delay;
    r.wakeup_marked = (op == OpPrime && !marked_safe(key)) ? 1'b0 : marked;
    r.now_us = now;
    void'(apply_op(r));
    pending_ops.push_back(r);
  endtask

  // Fill the stimulus queue, then replay the shadow state for checking
  initial begin
    logic [31:0] key;
    int op_sel;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hffff_ffff;

    // Directed: extremes, reinsert, not found, extended prime, full table, clear
    queue_op(OpRemove, 32'h1234_5678, 16'h0, 32'h0, 1'b0, 64'd0);
    queue_op(OpPrime, 32'h1234_5678, 16'h0, 32'h1, 1'b0, 64'd0);
    queue_op(OpInsert, key_pool[0], 16'hffff, 32'h0, 1'b0, 64'd0);
    queue_op(OpInsert, key_pool[1], 16'h0000, 32'h0, 1'b0, 64'd0);
    queue_op(OpInsert, key_pool[0], 16'h0400, 32'h0, 1'b0, 64'd0);
    queue_op(OpPrime, key_pool[0], 16'h0, 32'h8000_0000, 1'b0, '1);
    queue_op(OpPrime, key_pool[0], 16'h0, 32'h7fff_ffff, 1'b1, '1);
    queue_op(OpRemove, key_pool[0], 16'h0, 32'h0, 1'b1, 64'd5);
    queue_op(OpPrime, key_pool[1], 16'hfbff, 32'h7fff_ffff, 1'b1, 64'd0);
    queue_op(OpRemove, key_pool[1], 16'hffff, 32'hffff_ffff, 1'b1, 64'd0);
    queue_op(OpInsert, key_pool[1], 16'h0, 32'h0, 1'b0, 64'd100);
    queue_op(OpPrime, key_pool[1], 16'h0, 32'hffff_fc18, 1'b0, 64'd100);
    queue_op(OpRemove, key_pool[1], 16'h0, 32'h0, 1'b0, 64'd200);
    for (int i = 0; i < 66; i++) queue_op(OpInsert, 32'h100 + i, 16'h0, 32'h0, 1'b0, 64'd0);
    queue_op(OpClear, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b1, '1);

    // Random: mostly insert/prime/remove on a small key pool
    for (int i = 0; i < 900; i++) begin
      key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
      op_sel = $urandom_range(0, 99);
      if (op_sel < 30)
        queue_op(OpInsert, key, 16'($urandom), rand_delay(), 1'($urandom), rand_now());
      else if (op_sel < 65)
        queue_op(OpPrime, key, 16'($urandom), rand_delay(), 1'($urandom), rand_now());
      else if (op_sel < 97)
        queue_op(OpRemove, key, 16'($urandom), rand_delay(), 1'($urandom), rand_now());
      else
        queue_op(OpClear, key, 16'($urandom), rand_delay(), 1'($urandom), rand_now());
    end

    // Reset shadow so the driver can re-predict in accept order
    for (int j = 0; j < NumSlots; j++) begin
      tbl_valid[j] = 1'b0;
      tbl_active[j] = 1'b0;
      tbl_ext[j] = 1'b0;
      tbl_woken[j] = 1'b0;
      tbl_key[j] = '0;
      tbl_wake[j] = '0;
    end
    stim_done = 1'b1;
  end

  // Reset
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Quiet stretch with no idling on either side
  always @(posedge clk_i) begin
    pick_calls <= pick_calls + 1;
    quiet_mode <= (pick_calls > 20000 && pick_calls < 30000);
  end

  // Drive operations
  int sent = 0;
  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && stim_done) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(apply_op(req_ch.data));
        sent <= sent + 1;
      end
      if ((!req_ch.valid || req_ch.ready) ) begin
        if ((req_ch.valid && req_ch.ready ? sent + 1 : sent) < pending_ops.size() &&
            (quiet_mode || $urandom_range(0, 99) >= 18)) begin
          req_ch.valid <= 1'b1;
          req_ch.data <= pending_ops[req_ch.valid && req_ch.ready ? sent + 1 : sent];
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Check results
  initial rsp_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result item");
          error_count++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (rsp_ch.data.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, rsp_ch.data.status);
            error_count++;
          end
          if (rsp_ch.data.write_count !== exp_r.write_count) begin
            $error("write_count exp %0d got %0d", exp_r.write_count, rsp_ch.data.write_count);
            error_count++;
          end
          if (rsp_ch.data.count_value !== exp_r.count_value) begin
            $error("count_value exp %0d got %0d", exp_r.count_value, rsp_ch.data.count_value);
            error_count++;
          end
          if (rsp_ch.data.set_wakeup_mark !== exp_r.set_wakeup_mark) begin
            $error("set_wakeup_mark exp %0d got %0d", exp_r.set_wakeup_mark,
                   rsp_ch.data.set_wakeup_mark);
            error_count++;
          end
          if (rsp_ch.data.slot !== exp_r.slot) begin
            $error("slot exp %0d got %0d", exp_r.slot, rsp_ch.data.slot);
            error_count++;
          end
        end
      end
      rsp_ch.ready <= quiet_mode || ($urandom_range(0, 99) >= 18);
    end
  end

  // Finish once everything is accepted and answered
  initial begin
    wait (stim_done);
    wait (sent == pending_ops.size() && expected_rsps.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("tb_timer_task_descriptor_table: clean");
    end else begin
      $display("tb_timer_task_descriptor_table: errors");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("tb_timer_task_descriptor_table: errors");
    $finish;
  end
endmodule
